### sv/psu_pkg.sv
package psu_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
    localparam int COL_W         = $clog2(MAX_ROW_BYTES + 1);

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam int MAX_BPP = 4;

    // Filter codes carried by the first byte of every row.
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 1'b1;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       filter_error;
    } result_t;

endpackage

### sv/psu_recon.sv
module psu_recon
(
    input  logic [7:0] raw_byte,
    input  logic [2:0] filter_kind,
    input  logic [7:0] left_byte,
    input  logic [7:0] above_byte,
    input  logic [7:0] above_left_byte,
    output logic [7:0] pixel_byte
);

    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_sum;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth;

    // With p = a + b - c the three distances reduce to |b-c|, |a-c| and |a+b-2c|.
    always_comb
    begin
        d_bc    = $signed({2'b00, above_byte}) - $signed({2'b00, above_left_byte});
        d_ac    = $signed({2'b00, left_byte}) - $signed({2'b00, above_left_byte});
        d_sum   = d_bc + d_ac;
        pa      = (d_bc < 0) ? 10'(-d_bc) : 10'(d_bc);
        pb      = (d_ac < 0) ? 10'(-d_ac) : 10'(d_ac);
        pc      = (d_sum < 0) ? 10'(-d_sum) : 10'(d_sum);
        avg_sum = {1'b0, left_byte} + {1'b0, above_byte};

        priority if (pa <= pb && pa <= pc)
            paeth = left_byte;
        else if (pb <= pc)
            paeth = above_byte;
        else
            paeth = above_left_byte;

        unique case (filter_kind)
            psu_pkg::FILT_NONE:  pixel_byte = raw_byte;
            psu_pkg::FILT_SUB:   pixel_byte = raw_byte + left_byte;
            psu_pkg::FILT_UP:    pixel_byte = raw_byte + above_byte;
            psu_pkg::FILT_AVG:   pixel_byte = raw_byte + avg_sum[8:1];
            psu_pkg::FILT_PAETH: pixel_byte = raw_byte + paeth;
            default:             pixel_byte = raw_byte;
        endcase
    end

endmodule

### sv/psu_out_fifo.sv
module psu_out_fifo
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  psu_pkg::result_t                 push_data,
    input  logic                             pop,
    output logic                             out_valid,
    output psu_pkg::result_t                 out_data,
    output logic [psu_pkg::FIFO_CW-1:0]      count
);

    psu_pkg::result_t                  entry_reg [psu_pkg::FIFO_DEPTH];
    logic [psu_pkg::FIFO_AW-1:0]       head_reg;
    logic [psu_pkg::FIFO_AW-1:0]       head_next;
    logic [psu_pkg::FIFO_AW-1:0]       tail_reg;
    logic [psu_pkg::FIFO_AW-1:0]       tail_next;
    logic [psu_pkg::FIFO_CW-1:0]       count_reg;
    logic [psu_pkg::FIFO_CW-1:0]       count_next;
    logic                              do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[head_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        head_next  = do_pop ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + psu_pkg::FIFO_CW'(push) - psu_pkg::FIFO_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |-> (count_reg < psu_pkg::FIFO_CW'(psu_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule

### sv/png_scanline_unfilter_unit.sv
// A data byte accepted at the front stage is registered into the second stage and its word
// is pushed into the output queue from there. Throughput: one stream byte per cycle while the
// output queue has room, set by one line store read and one write each cycle.
// Filter bytes give no result; a bad filter code gives one error word.
// Reset clears all control state and the histories; the line store keeps its contents
// and needs no clearing pass, since each row above is written before it is read.
module png_scanline_unfilter_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // [7:0] raw_byte
    input  logic                                s_tuser,    // [0] image_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // [7:0] pixel_byte
    output logic                                m_tlast,
    output logic                                m_tuser     // [0] filter_error
);

    localparam int ADDR_W = psu_pkg::ADDR_W;
    localparam int COL_W  = psu_pkg::COL_W;

    // Configuration.
    logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [psu_pkg::BPP_W-1:0]       bpp_reg;
    logic [COL_W-1:0]                eff_row_bytes;
    logic [1:0]                      bpp_sel;

    // Front control state.
    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic [2:0]       filter_kind_reg;
    logic [2:0]       filter_kind_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic             error_hold_reg;
    logic             error_hold_next;

    logic             accept;
    logic [COL_W-1:0] col_eff;
    logic             first_eff;
    logic             hold_eff;
    logic             is_data;
    logic             is_filter;
    logic             is_bad;
    logic             clear_hist;
    logic             row_last;
    logic [ADDR_W-1:0] rd_addr;

    // Second stage.
    logic              s1_data_reg;
    logic              s1_err_reg;
    logic [7:0]        s1_raw_reg;
    logic [2:0]        s1_kind_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s1_idx_reg;

    logic [31:0] left_hist_reg;
    logic [31:0] left_hist_next;
    logic [31:0] upleft_hist_reg;
    logic [31:0] upleft_hist_next;

    logic [7:0] line_store [psu_pkg::MAX_ROW_BYTES];
    logic [7:0] rd_data_reg;

    logic [7:0] a_byte;
    logic [7:0] b_byte;
    logic [7:0] c_byte;
    logic [7:0] pixel;

    logic                         fifo_push;
    psu_pkg::result_t             fifo_in;
    psu_pkg::result_t             fifo_out;
    logic [psu_pkg::FIFO_CW-1:0]  fifo_count;
    logic [psu_pkg::FIFO_CW:0]    pending;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= psu_pkg::ROW_BYTES_W'(1);
            bpp_reg       <= psu_pkg::BPP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psu_pkg::CFG_ROW_BYTES: row_bytes_reg <= cfg_data[psu_pkg::ROW_BYTES_W-1:0];
                psu_pkg::CFG_BPP:       bpp_reg       <= cfg_data[psu_pkg::BPP_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        priority if (row_bytes_reg == '0)
            eff_row_bytes = COL_W'(1);
        else if (COL_W'(row_bytes_reg) > COL_W'(psu_pkg::MAX_ROW_BYTES))
            eff_row_bytes = COL_W'(psu_pkg::MAX_ROW_BYTES);
        else
            eff_row_bytes = COL_W'(row_bytes_reg);

        priority if (bpp_reg == '0)
            bpp_sel = 2'd0;
        else if (bpp_reg > psu_pkg::BPP_W'(psu_pkg::MAX_BPP))
            bpp_sel = 2'(psu_pkg::MAX_BPP - 1);
        else
            bpp_sel = 2'(bpp_reg - 1'b1);
    end

    // ---------------- front stage ----------------
    // Room is kept for the word in the second stage, so that stage never stalls and the
    // registered line store data is always consumed in the cycle after the read.
    assign pending  = {1'b0, fifo_count} + (psu_pkg::FIFO_CW + 1)'(s1_data_reg || s1_err_reg);
    assign s_tready = (pending <= (psu_pkg::FIFO_CW + 1)'(psu_pkg::FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        col_eff   = s_tuser ? '0 : column_reg;
        first_eff = s_tuser ? 1'b1 : first_row_reg;
        hold_eff  = s_tuser ? 1'b0 : error_hold_reg;
        is_filter = !hold_eff && (col_eff == '0);
        is_bad    = is_filter && (s_tdata > 8'(psu_pkg::FILT_PAETH));
        is_data   = !hold_eff && (col_eff != '0);
        row_last  = (col_eff >= eff_row_bytes);
        rd_addr   = ADDR_W'(col_eff - 1'b1);
        clear_hist = accept && (s_tuser || is_filter);

        column_next      = column_reg;
        filter_kind_next = filter_kind_reg;
        first_row_next   = first_row_reg;
        error_hold_next  = error_hold_reg;

        if (accept)
        begin
            column_next     = col_eff;
            first_row_next  = first_eff;
            error_hold_next = hold_eff;
            if (s_tuser)
                filter_kind_next = psu_pkg::FILT_NONE;
            if (is_bad)
                error_hold_next = 1'b1;
            else if (is_filter)
            begin
                filter_kind_next = s_tdata[2:0];
                column_next      = COL_W'(1);
            end
            else if (is_data)
            begin
                if (row_last)
                begin
                    column_next    = '0;
                    first_row_next = 1'b0;
                end
                else
                    column_next = col_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            filter_kind_reg <= psu_pkg::FILT_NONE;
            first_row_reg   <= 1'b1;
            error_hold_reg  <= 1'b0;
            s1_data_reg     <= 1'b0;
            s1_err_reg      <= 1'b0;
        end
        else
        begin
            column_reg      <= column_next;
            filter_kind_reg <= filter_kind_next;
            first_row_reg   <= first_row_next;
            error_hold_reg  <= error_hold_next;
            s1_data_reg     <= accept && is_data;
            s1_err_reg      <= accept && is_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_raw_reg   <= s_tdata;
            s1_kind_reg  <= filter_kind_reg;
            s1_first_reg <= first_eff;
            s1_last_reg  <= row_last;
            s1_idx_reg   <= rd_addr;
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge clk)
    begin
        if (accept && is_data)
            rd_data_reg <= line_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_data_reg)
            line_store[s1_idx_reg] <= pixel;
    end

    // ---------------- reconstruction stage ----------------
    always_comb
    begin
        a_byte = left_hist_reg[8*bpp_sel +: 8];
        b_byte = s1_first_reg ? 8'h00 : rd_data_reg;
        c_byte = s1_first_reg ? 8'h00 : upleft_hist_reg[8*bpp_sel +: 8];
    end

    psu_recon u_recon
    (
        .raw_byte        (s1_raw_reg),
        .filter_kind     (s1_kind_reg),
        .left_byte       (a_byte),
        .above_byte      (b_byte),
        .above_left_byte (c_byte),
        .pixel_byte      (pixel)
    );

    // A filter byte accepted at the same edge belongs to a later row, so its clear wins.
    always_comb
    begin
        left_hist_next   = left_hist_reg;
        upleft_hist_next = upleft_hist_reg;
        if (clear_hist)
        begin
            left_hist_next   = '0;
            upleft_hist_next = '0;
        end
        else if (s1_data_reg)
        begin
            left_hist_next   = {left_hist_reg[23:0], pixel};
            upleft_hist_next = {upleft_hist_reg[23:0], b_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_hist_reg   <= '0;
            upleft_hist_reg <= '0;
        end
        else
        begin
            left_hist_reg   <= left_hist_next;
            upleft_hist_reg <= upleft_hist_next;
        end
    end

    // ---------------- output queue ----------------
    always_comb
    begin
        fifo_push = s1_data_reg || s1_err_reg;
        if (s1_err_reg)
        begin
            fifo_in.pixel_byte   = 8'h00;
            fifo_in.row_end      = 1'b0;
            fifo_in.filter_error = 1'b1;
        end
        else
        begin
            fifo_in.pixel_byte   = pixel;
            fifo_in.row_end      = s1_last_reg;
            fifo_in.filter_error = 1'b0;
        end
    end

    psu_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = fifo_out.pixel_byte;
    assign m_tlast = fifo_out.row_end;
    assign m_tuser = fifo_out.filter_error;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_data && s1_data_reg) |-> (rd_addr != s1_idx_reg))
        else $error("line store read and write hit the same entry");

    a_err_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_err_reg |-> error_hold_reg)
        else $error("error word without error hold");

    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(psu_pkg::MAX_ROW_BYTES))
        else $error("column beyond line store");

    a_single_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_data_reg && s1_err_reg))
        else $error("second stage holds both a data and an error word");
`endif

endmodule

### bench/png_scanline_unfilter_unit_test.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_unit_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 350;
    localparam int WIDE_BYTES   = 40;

    typedef struct packed {
        logic [7:0] raw;
        logic       start;
    } stream_byte_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [psu_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;    // [7:0] raw_byte
    logic                           s_tuser   = 1'b0;  // [0] image_start
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;           // [7:0] pixel_byte
    logic                           m_tlast;
    logic                           m_tuser;           // [0] filter_error

    stream_byte_t     pending_bytes[$];
    psu_pkg::result_t expected_pixels[$];
    int               errors       = 0;
    bit               word_held    = 1'b0;
    bit               calm         = 1'b0;
    bit               hold_req     = 1'b0;
    int               hold_left    = 0;
    int               stall_cycles = 0;

    // Mirror of the unfilter state and its two registers.
    logic [7:0]                      row_above [psu_pkg::MAX_ROW_BYTES];
    int                              col            = 0;
    logic [2:0]                      cur_filter     = psu_pkg::FILT_NONE;
    bit                              top_row        = 1'b1;
    bit                              dropping       = 1'b0;
    logic [31:0]                     left_bytes     = '0;
    logic [31:0]                     upleft_bytes   = '0;
    logic [psu_pkg::ROW_BYTES_W-1:0] row_len_reg    = psu_pkg::ROW_BYTES_W'(1);
    logic [psu_pkg::BPP_W-1:0]       pixel_step_reg = psu_pkg::BPP_W'(1);

    png_scanline_unfilter_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic int row_len();
        if (row_len_reg == 0)
            return 1;
        if (int'(row_len_reg) > psu_pkg::MAX_ROW_BYTES)
            return psu_pkg::MAX_ROW_BYTES;
        return int'(row_len_reg);
    endfunction

    function automatic int pixel_step();
        if (pixel_step_reg == 0)
            return 1;
        if (int'(pixel_step_reg) > psu_pkg::MAX_BPP)
            return psu_pkg::MAX_BPP;
        return int'(pixel_step_reg);
    endfunction

    function automatic logic [7:0] paeth_predict(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc)
            return a[7:0];
        return (pb <= pc) ? b[7:0] : c[7:0];
    endfunction

    // Returns 1 when the stream byte yields a word, which is then placed in res.
    function automatic bit unfilter_byte(input logic [7:0] raw, input logic start,
                                         output psu_pkg::result_t res);
        int         idx;
        int         shift;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] v;
        logic [8:0] pair_sum;
        res = '0;
        if (start)
        begin
            col          = 0;
            cur_filter   = psu_pkg::FILT_NONE;
            top_row      = 1'b1;
            dropping     = 1'b0;
            left_bytes   = '0;
            upleft_bytes = '0;
        end
        if (dropping)
            return 1'b0;
        if (col == 0)
        begin
            if (raw > 8'(psu_pkg::FILT_PAETH))
            begin
                dropping         = 1'b1;
                res.filter_error = 1'b1;
                return 1'b1;
            end
            cur_filter   = raw[2:0];
            left_bytes   = '0;
            upleft_bytes = '0;
            col          = 1;
            return 1'b0;
        end

        idx = col - 1;
        if (idx >= psu_pkg::MAX_ROW_BYTES)
            idx = psu_pkg::MAX_ROW_BYTES - 1;
        shift = (pixel_step() - 1) * 8;
        a = 8'(left_bytes >> shift);
        b = top_row ? 8'h00 : row_above[idx];
        c = top_row ? 8'h00 : 8'(upleft_bytes >> shift);
        pair_sum = {1'b0, a} + {1'b0, b};
        case (cur_filter)
            psu_pkg::FILT_SUB:   v = raw + a;
            psu_pkg::FILT_UP:    v = raw + b;
            psu_pkg::FILT_AVG:   v = raw + pair_sum[8:1];
            psu_pkg::FILT_PAETH: v = raw + paeth_predict(int'(a), int'(b), int'(c));
            default:             v = raw;
        endcase

        row_above[idx] = v;
        left_bytes     = {left_bytes[23:0], v};
        upleft_bytes   = {upleft_bytes[23:0], b};
        res.pixel_byte = v;
        res.row_end    = (col >= row_len());
        if (res.row_end)
        begin
            col     = 0;
            top_row = 1'b0;
        end
        else
        begin
            col++;
        end
        return 1'b1;
    endfunction

    // Output words are checked before the input word of the same edge is predicted.
    always @(posedge clk)
    begin : check_and_predict
        psu_pkg::result_t got;
        psu_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{pixel_byte: m_tdata, row_end: m_tlast, filter_error: m_tuser};
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected word: pixel_byte %0h row_end %0b filter_error %0b",
                           got.pixel_byte, got.row_end, got.filter_error);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_byte !== want.pixel_byte)
                    begin
                        $error("pixel_byte: expected %0h, actual %0h",
                               want.pixel_byte, got.pixel_byte);
                        errors++;
                    end
                    if (got.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
                        errors++;
                    end
                    if (got.filter_error !== want.filter_error)
                    begin
                        $error("filter_error: expected %0b, actual %0b",
                               want.filter_error, got.filter_error);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                word_held = 1'b0;
                if (unfilter_byte(s_tdata, s_tuser, want))
                    expected_pixels.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk)
    begin : drive_stream
        stream_byte_t nxt;
        if (!word_held)
        begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 36))
            begin
                nxt = pending_bytes.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= nxt.raw;
                s_tuser   <= nxt.start;
                word_held = 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    task automatic send(input logic [7:0] raw, input logic start);
        pending_bytes.push_back('{raw: raw, start: start});
    endtask

    // One filter byte followed by count data bytes of random content.
    task automatic push_row(input logic [7:0] filter, input logic start, input int count);
        send(filter, start);
        repeat (count)
            send(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[psu_pkg::CFG_DATA_W-1:0];
        if (idx == psu_pkg::CFG_ROW_BYTES)
            row_len_reg = value[psu_pkg::ROW_BYTES_W-1:0];
        else
            pixel_step_reg = value[psu_pkg::BPP_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Filter bytes give no word, so a drain period after the queues empty lets the block settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || word_held || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          fed;
        int          rows;
        int          pick;
        int          cut;
        int unsigned width;
        bit          fresh;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every filter kind on a three byte row, with wrapping sums.
        write_reg(psu_pkg::CFG_ROW_BYTES, 3);
        write_reg(psu_pkg::CFG_BPP, 1);
        send(8'(psu_pkg::FILT_NONE), 1'b1);
        send(8'h00, 1'b0); send(8'hFF, 1'b0); send(8'h80, 1'b0);
        send(8'(psu_pkg::FILT_SUB), 1'b0);
        send(8'hFF, 1'b0); send(8'h01, 1'b0); send(8'h7F, 1'b0);
        send(8'(psu_pkg::FILT_UP), 1'b0);
        send(8'hFF, 1'b0); send(8'hFF, 1'b0); send(8'h00, 1'b0);
        send(8'(psu_pkg::FILT_AVG), 1'b0);
        send(8'h80, 1'b0); send(8'hFF, 1'b0); send(8'h01, 1'b0);
        send(8'(psu_pkg::FILT_PAETH), 1'b0);
        send(8'h10, 1'b0); send(8'hF0, 1'b0); send(8'h55, 1'b0);
        // A bad filter code drops everything up to the next image start.
        send(8'hFF, 1'b0);      send(8'h12, 1'b0); send(8'h00, 1'b1);
        send(8'h05, 1'b1);      send(8'h03, 1'b0);

        // Both registers written as zero act as one.
        wait_idle();
        write_reg(psu_pkg::CFG_ROW_BYTES, 0);
        write_reg(psu_pkg::CFG_BPP, 0);
        push_row(8'(psu_pkg::FILT_SUB), 1'b1, row_len());
        push_row(8'(psu_pkg::FILT_AVG), 1'b0, row_len());
        push_row(8'(psu_pkg::FILT_PAETH), 1'b0, row_len());

        // A pixel step above four acts as four; then the row is shortened part way.
        wait_idle();
        write_reg(psu_pkg::CFG_ROW_BYTES, 6);
        write_reg(psu_pkg::CFG_BPP, 7);
        push_row(8'(psu_pkg::FILT_SUB), 1'b1, row_len());
        push_row(8'(psu_pkg::FILT_PAETH), 1'b0, row_len());
        push_row(8'(psu_pkg::FILT_AVG), 1'b0, 4);
        wait_idle();
        write_reg(psu_pkg::CFG_ROW_BYTES, 2);
        send(8'hA5, 1'b0);
        push_row(8'(psu_pkg::FILT_UP), 1'b0, row_len());
        wait_idle();
        write_reg(psu_pkg::CFG_BPP, 2);
        push_row(8'(psu_pkg::FILT_SUB), 1'b0, row_len());
        push_row(8'(psu_pkg::FILT_PAETH), 1'b0, row_len());

        // A row length above the line store saturates; with no idling on either side,
        // a long row is abandoned part way by the next image start.
        wait_idle();
        calm = 1'b1;
        write_reg(psu_pkg::CFG_ROW_BYTES, 16383);
        write_reg(psu_pkg::CFG_BPP, 3);
        push_row(8'(psu_pkg::FILT_SUB), 1'b1, WIDE_BYTES);
        wait_idle();
        calm = 1'b0;

        // The receiver holds off while the sender keeps offering words.
        write_reg(psu_pkg::CFG_ROW_BYTES, 16);
        write_reg(psu_pkg::CFG_BPP, 2);
        hold_req = 1'b1;
        push_row(8'(psu_pkg::FILT_SUB), 1'b1, row_len());
        push_row(8'(psu_pkg::FILT_AVG), 1'b0, row_len());
        push_row(8'(psu_pkg::FILT_PAETH), 1'b0, row_len());

        fed = 0;
        while (fed < RANDOM_BYTES)
        begin
            wait_idle();
            width = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                 : $urandom_range(0, 24);
            write_reg(psu_pkg::CFG_ROW_BYTES, width);
            write_reg(psu_pkg::CFG_BPP, $urandom_range(0, 7));
            calm  = ($urandom_range(0, 5) == 0);
            fresh = 1'b1;
            rows  = $urandom_range(1, 5);
            for (int r = 0; r < rows; r++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    send(8'($urandom_range(psu_pkg::FILT_PAETH + 1, 255)), fresh);
                    repeat ($urandom_range(0, 4))
                        send(8'($urandom_range(0, 255)), 1'b0);
                    fed++;
                    break;
                end
                // A cut row is abandoned by starting a new image.
                cut = (pick == 1) ? $urandom_range(0, row_len() - 1) : row_len();
                push_row(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)),
                         fresh, cut);
                fed += cut + 1;
                fresh = (pick == 1);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/psu_pkg.sv
sv/psu_recon.sv
sv/psu_out_fifo.sv
sv/png_scanline_unfilter_unit.sv
bench/png_scanline_unfilter_unit_test.sv
